// ===== src/rmqi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmqi_pkg: shared types and constants
// Widths, depths and request codes for the range maximum index block.
// ----------------------------------------------------------------------------
package rmqi_pkg;

  localparam int unsigned MaxElements = 1024;
  localparam int unsigned PosWidth    = 10;
  localparam int unsigned CountWidth  = 11;
  localparam int unsigned ValueWidth  = 32;

  typedef enum logic [1:0] {
    ModeAppend = 2'd0,
    ModeQuery  = 2'd1,
    ModeClear  = 2'd2,
    ModeUnused = 2'd3
  } mode_e;

  localparam logic StatusOk      = 1'b0;
  localparam logic StatusInvalid = 1'b1;

endpackage

// ===== src/range_max_query_index.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_max_query_index: leftmost range maximum over a loaded array
// Appends values into an element memory with one write port and one read port
// and answers [left,right] queries by scanning the memory one element per cycle.
// ----------------------------------------------------------------------------
// Append and clear leave the block idle and ready; an invalid query goes from
// idle to the finish state, a valid query through the scan and drain states,
// its scan set by the one read port of the element memory (one element per cycle).
// One item at a time; a new item is accepted once the previous query has moved
// its result into the output register.
// Reset clears the element count, the control state and the output valid; the
// element memory is not cleared, only positions below the count are used in a result.
module range_max_query_index (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic [31:0]                   value_i,
  input  logic [9:0]                    left_i,
  input  logic [9:0]                    right_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [9:0]                    position_o,
  output logic                          status_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StFinish
  } state_e;

  localparam int unsigned PW = rmqi_pkg::PosWidth;
  localparam int unsigned CW = rmqi_pkg::CountWidth;
  localparam int unsigned VW = rmqi_pkg::ValueWidth;

  logic [VW-1:0] mem_q [rmqi_pkg::MaxElements];

  state_e        state_q;
  logic [CW-1:0] count_q;
  logic [PW-1:0] scan_q, hi_q, rd_idx_q, best_pos_q;
  logic [VW-1:0] rdata_q, best_val_q;
  logic          data_vld_q, have_best_q, err_q;
  logic          out_valid_q, status_q;
  logic [PW-1:0] position_q;
  logic          in_acc;
  logic          out_free;
  logic          take_new;

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign position_o  = position_q;
  assign status_o    = status_q;

  // candidate replaces best on a strictly larger value: ties stay leftmost
  assign take_new = data_vld_q && (!have_best_q || (rdata_q > best_val_q));

  // element memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_acc && (mode_i == rmqi_pkg::ModeAppend) &&
        (count_q < CW'(rmqi_pkg::MaxElements))) begin
      mem_q[count_q[PW-1:0]] <= value_i;
    end
    rdata_q  <= mem_q[scan_q];
    rd_idx_q <= scan_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      scan_q      <= '0;
      hi_q        <= '0;
      best_pos_q  <= '0;
      best_val_q  <= '0;
      data_vld_q  <= 1'b0;
      have_best_q <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= rmqi_pkg::StatusOk;
      position_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      data_vld_q <= (state_q == StScan);
      if (take_new) begin
        best_val_q  <= rdata_q;
        best_pos_q  <= rd_idx_q;
        have_best_q <= 1'b1;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            case (mode_i)
              rmqi_pkg::ModeAppend: begin
                if (count_q < CW'(rmqi_pkg::MaxElements)) begin
                  count_q <= count_q + CW'(1);
                end
              end
              rmqi_pkg::ModeClear: begin
                count_q <= '0;
              end
              rmqi_pkg::ModeQuery: begin
                have_best_q <= 1'b0;
                scan_q      <= left_i;
                hi_q        <= right_i;
                if ((left_i > right_i) || ({1'b0, right_i} >= count_q)) begin
                  err_q   <= 1'b1;
                  state_q <= StFinish;
                end else begin
                  err_q   <= 1'b0;
                  state_q <= StScan;
                end
              end
              default: ;
            endcase
          end
        end
        StScan: begin
          // advance one element a cycle through the range
          if (scan_q == hi_q) begin
            state_q <= StDrain;
          end else begin
            scan_q <= scan_q + PW'(1);
          end
        end
        StDrain: begin
          // last read data is compared this cycle
          state_q <= StFinish;
        end
        StFinish: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= err_q ? rmqi_pkg::StatusInvalid : rmqi_pkg::StatusOk;
            position_q  <= err_q ? '0 : best_pos_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(rmqi_pkg::MaxElements))
    else $error("element count beyond capacity");

  a_err_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == rmqi_pkg::StatusInvalid)) |-> (position_q == '0))
    else $error("invalid query with nonzero position");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish && !err_q) |-> (best_pos_q <= hi_q))
    else $error("answer beyond range end");

endmodule

// ===== tb/sv/tb_range_max_query_index.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_max_query_index: self-checking bench for the range maximum block
// Loads arrays, clears them and fires range queries with random gaps on both
// sides; a scoreboard tracks the loaded array and checks each answer.
// ----------------------------------------------------------------------------
module tb_range_max_query_index;

  class rmq_scoreboard;
    logic [rmqi_pkg::ValueWidth-1:0] elems[rmqi_pkg::MaxElements];
    int unsigned elem_cnt;
    logic [rmqi_pkg::PosWidth-1:0] exp_pos[$];
    logic exp_status[$];
    int unsigned errors;

    function void note_beat(logic [1:0] mode, logic [31:0] value,
                            logic [9:0] lo, logic [9:0] hi);
      int unsigned best;
      if (mode == rmqi_pkg::ModeAppend) begin
        if (elem_cnt < rmqi_pkg::MaxElements) begin
          elems[elem_cnt] = value;
          elem_cnt++;
        end
      end else if (mode == rmqi_pkg::ModeClear) begin
        elem_cnt = 0;
      end else if (mode == rmqi_pkg::ModeQuery) begin
        if (lo > hi || hi >= elem_cnt) begin
          exp_pos.push_back('0);
          exp_status.push_back(rmqi_pkg::StatusInvalid);
        end else begin
          best = lo;
          for (int unsigned k = lo + 1; k <= hi; k++)
            if (elems[k] > elems[best]) best = k;
          exp_pos.push_back(best[rmqi_pkg::PosWidth-1:0]);
          exp_status.push_back(rmqi_pkg::StatusOk);
        end
      end
    endfunction

    function void check_result(logic [9:0] pos, logic st);
      logic [rmqi_pkg::PosWidth-1:0] ep;
      logic es;
      if (exp_pos.size() == 0) begin
        $error("unexpected result position=%0d status=%0d", pos, st);
        errors++;
        return;
      end
      ep = exp_pos.pop_front();
      es = exp_status.pop_front();
      if (pos !== ep) begin
        $error("position: expected %0d actual %0d", ep, pos);
        errors++;
      end
      if (st !== es) begin
        $error("status: expected %0d actual %0d", es, st);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [1:0] mode_i = '0;
  logic [31:0] value_i = '0;
  logic [9:0] left_i = '0;
  logic [9:0] right_i = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o, status_o;
  logic [9:0] position_o;

  rmq_scoreboard sb = new();
  int unsigned cycle_cnt = 0;
  bit hold_off = 1'b0;

  range_max_query_index DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3_000_000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Monitor both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_beat(mode_i, value_i, left_i, right_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(position_o, status_o);
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off.
  initial begin
    int unsigned g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      if (cycle_cnt % 1000 < 300) begin
        out_ready_i <= 1'b1;
      end else begin
        g = gap_len();
        if (g == 0) out_ready_i <= 1'b1;
        else begin
          out_ready_i <= 1'b0;
          repeat (g - 1) @(negedge clk_i);
        end
      end
    end
  end

  // Keep valid high between back-to-back beats; drop it only for a gap.
  task automatic send_beat(logic [1:0] mode, logic [31:0] value,
                           logic [9:0] lo, logic [9:0] hi, bit gaps);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    value_i <= value;
    left_i <= lo;
    right_i <= hi;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 3);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 2);
      default: return $urandom();
    endcase
  endfunction

  // Query mostly inside the loaded range, sometimes broken.
  task automatic rand_query(int unsigned cnt, bit gaps);
    int unsigned lo, hi;
    if (cnt == 0 || $urandom_range(0, 9) == 0) begin
      send_beat(rmqi_pkg::ModeQuery, $urandom(), 10'($urandom()), 10'($urandom()), gaps);
    end else begin
      lo = $urandom_range(0, cnt - 1);
      hi = $urandom_range(lo, (lo + 12 < cnt) ? lo + 12 : cnt - 1);
      if ($urandom_range(0, 9) == 0) hi = $urandom_range(0, cnt - 1);
      send_beat(rmqi_pkg::ModeQuery, $urandom(), lo[9:0], hi[9:0], gaps);
    end
  endtask

  initial begin
    int unsigned n;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty array, ties, extremes, unused mode, clear.
    send_beat(rmqi_pkg::ModeQuery, '0, 10'd0, 10'd0, 1'b0);
    send_beat(rmqi_pkg::ModeUnused, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF, 1'b0);
    send_beat(rmqi_pkg::ModeAppend, 32'hFFFF_FFFF, '0, '0, 1'b0);
    send_beat(rmqi_pkg::ModeAppend, 32'd0, 10'h3FF, 10'h3FF, 1'b0);
    send_beat(rmqi_pkg::ModeAppend, 32'hFFFF_FFFF, '0, '0, 1'b0);
    send_beat(rmqi_pkg::ModeAppend, 32'd5, '0, '0, 1'b0);
    send_beat(rmqi_pkg::ModeQuery, '0, 10'd0, 10'd3, 1'b0);
    send_beat(rmqi_pkg::ModeQuery, '0, 10'd1, 10'd3, 1'b0);
    send_beat(rmqi_pkg::ModeQuery, '0, 10'd3, 10'd3, 1'b0);
    send_beat(rmqi_pkg::ModeQuery, '0, 10'd3, 10'd1, 1'b0);
    send_beat(rmqi_pkg::ModeQuery, '0, 10'd0, 10'd4, 1'b0);
    send_beat(rmqi_pkg::ModeQuery, '0, 10'h3FF, 10'h3FF, 1'b0);
    send_beat(rmqi_pkg::ModeClear, '0, '0, '0, 1'b0);
    send_beat(rmqi_pkg::ModeQuery, '0, 10'd0, 10'd0, 1'b0);

    // Fill the array to capacity, overflow once, then query wide ranges.
    for (int i = 0; i < rmqi_pkg::MaxElements + 1; i++)
      send_beat(rmqi_pkg::ModeAppend, rand_value(), 10'($urandom()), 10'($urandom()), 1'b0);
    send_beat(rmqi_pkg::ModeQuery, '0, 10'd0, 10'h3FF, 1'b0);
    send_beat(rmqi_pkg::ModeQuery, '0, 10'h3FE, 10'h3FF, 1'b0);
    send_beat(rmqi_pkg::ModeQuery, '0, 10'd500, 10'd520, 1'b0);

    // Long receiver hold-off while queries keep coming.
    hold_off = 1'b1;
    for (int i = 0; i < 8; i++) rand_query(sb.elem_cnt, 1'b0);

    // Random phases: clear, load a small array, query it.
    n = 0;
    while (n < 500) begin
      send_beat(rmqi_pkg::ModeClear, $urandom(), 10'($urandom()), 10'($urandom()), 1'b1);
      repeat ($urandom_range(1, 24)) begin
        send_beat(rmqi_pkg::ModeAppend, rand_value(), 10'($urandom()), 10'($urandom()),
                  1'b1);
        n++;
      end
      repeat ($urandom_range(4, 20)) begin
        if ($urandom_range(0, 15) == 0)
          send_beat(rmqi_pkg::ModeAppend, rand_value(), 10'($urandom()), 10'($urandom()),
                    1'b1);
        else if ($urandom_range(0, 30) == 0)
          send_beat(rmqi_pkg::ModeUnused, $urandom(), 10'($urandom()), 10'($urandom()),
                    1'b1);
        else
          rand_query(sb.elem_cnt, 1'b1);
        n++;
      end
    end

    in_valid_i <= 1'b0;
    while (sb.exp_pos.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
